/* design/hcts_pkg.sv */
// shared types, character codes and word tables for the close tag scanner
package hcts_pkg;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDq    = 8'h22;
  localparam logic [7:0] ChSq    = 8'h27;

  typedef enum logic [1:0] {
    KIND_SCRIPT = 2'd0,
    KIND_STYLE  = 2'd1,
    KIND_HEAD   = 2'd2,
    KIND_ALT    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_SLASH = 2'd1,
    PH_WORD  = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    VER_OPEN  = 2'd0,
    VER_MATCH = 2'd1,
    VER_FAIL  = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    QT_NONE   = 2'd0,
    QT_DOUBLE = 2'd1,
    QT_SINGLE = 2'd2
  } quote_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } step_t;

  typedef struct packed {
    logic valid;
    logic status;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
  endfunction

  function automatic logic [2:0] word_len(input kind_e k);
    logic [2:0] n;
    unique case (k)
      KIND_STYLE: n = 3'd5;
      KIND_HEAD:  n = 3'd4;
      default:    n = 3'd6;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] word_char(input kind_e k, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (k)
      KIND_STYLE: begin
        case (pos)
          3'd0:    ch = 8'h73;
          3'd1:    ch = 8'h74;
          3'd2:    ch = 8'h79;
          3'd3:    ch = 8'h6C;
          3'd4:    ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      KIND_HEAD: begin
        case (pos)
          3'd0:    ch = 8'h68;
          3'd1:    ch = 8'h65;
          3'd2:    ch = 8'h61;
          3'd3:    ch = 8'h64;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (pos)
          3'd0:    ch = 8'h73;
          3'd1:    ch = 8'h63;
          3'd2:    ch = 8'h72;
          3'd3:    ch = 8'h69;
          3'd4:    ch = 8'h70;
          3'd5:    ch = 8'h74;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

endpackage

/* design/hcts_scan.sv */
// scan state registers and the per-byte tag and close word matcher
module hcts_scan #(
  parameter int TAG_BUFFER_SIZE = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  hcts_pkg::step_t  item_i,
  input  hcts_pkg::kind_e  kind_i,
  output hcts_pkg::res_t   res_o
);

  localparam int LenW = $clog2(TAG_BUFFER_SIZE);
  localparam logic [LenW-1:0] LenLimit = LenW'(TAG_BUFFER_SIZE - 2);

  logic                 inside_q, inside_d;
  logic [LenW-1:0]      len_q, len_d;
  hcts_pkg::quote_e     quote_q, quote_d;
  hcts_pkg::phase_e     phase_q, phase_d;
  logic [2:0]           pos_q, pos_d;
  hcts_pkg::verdict_e   verdict_q, verdict_d;

  logic [7:0] c;
  logic       ended;
  logic       matched;
  logic [2:0] wlen;

  assign c    = item_i.data_byte;
  assign wlen = hcts_pkg::word_len(kind_i);

  always_comb begin
    inside_d  = inside_q;
    len_d     = len_q;
    quote_d   = quote_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    verdict_d = verdict_q;
    ended     = 1'b0;
    matched   = 1'b0;
    res_o     = '0;
    if (item_i.end_of_stream) begin
      inside_d     = 1'b0;
      len_d        = '0;
      quote_d      = hcts_pkg::QT_NONE;
      phase_d      = hcts_pkg::PH_LEAD;
      pos_d        = '0;
      verdict_d    = hcts_pkg::VER_OPEN;
      res_o.valid  = 1'b1;
      res_o.status = 1'b1;
    end else if (!inside_q) begin
      if (c == hcts_pkg::ChLt) begin
        inside_d  = 1'b1;
        len_d     = LenW'(1);
        quote_d   = hcts_pkg::QT_NONE;
        phase_d   = hcts_pkg::PH_LEAD;
        pos_d     = '0;
        verdict_d = hcts_pkg::VER_OPEN;
      end
    end else begin
      len_d = len_q + LenW'(1);
      // close word matcher, ignores quoting
      if (verdict_q == hcts_pkg::VER_OPEN) begin
        unique case (phase_q)
          hcts_pkg::PH_LEAD: begin
            if (c == hcts_pkg::ChSlash) begin
              phase_d = hcts_pkg::PH_SLASH;
            end else if (!hcts_pkg::is_ws(c)) begin
              verdict_d = hcts_pkg::VER_FAIL;
            end
          end
          hcts_pkg::PH_SLASH, hcts_pkg::PH_WORD: begin
            if (!((phase_q == hcts_pkg::PH_SLASH) && hcts_pkg::is_ws(c))) begin
              if ((pos_q < wlen) &&
                  (hcts_pkg::to_lower(c) == hcts_pkg::word_char(kind_i, pos_q))) begin
                pos_d   = pos_q + 3'd1;
                phase_d = ((pos_q + 3'd1) >= wlen) ? hcts_pkg::PH_DONE
                                                   : hcts_pkg::PH_WORD;
              end else begin
                verdict_d = hcts_pkg::VER_FAIL;
              end
            end
          end
          default: begin
            if (hcts_pkg::is_ws(c) || (c == hcts_pkg::ChGt) || (c == hcts_pkg::ChSlash)) begin
              verdict_d = hcts_pkg::VER_MATCH;
            end else begin
              verdict_d = hcts_pkg::VER_FAIL;
            end
          end
        endcase
      end
      // quote tracking and tag end
      if (quote_q != hcts_pkg::QT_NONE) begin
        if (((quote_q == hcts_pkg::QT_DOUBLE) && (c == hcts_pkg::ChDq)) ||
            ((quote_q == hcts_pkg::QT_SINGLE) && (c == hcts_pkg::ChSq))) begin
          quote_d = hcts_pkg::QT_NONE;
        end
      end else if (c == hcts_pkg::ChDq) begin
        quote_d = hcts_pkg::QT_DOUBLE;
      end else if (c == hcts_pkg::ChSq) begin
        quote_d = hcts_pkg::QT_SINGLE;
      end else if (c == hcts_pkg::ChGt) begin
        ended = 1'b1;
      end
      if (len_d >= LenLimit) begin
        ended = 1'b1;
      end
      if (ended) begin
        matched = (verdict_d == hcts_pkg::VER_MATCH) ||
                  ((verdict_d == hcts_pkg::VER_OPEN) && (phase_d == hcts_pkg::PH_DONE));
        inside_d     = 1'b0;
        len_d        = '0;
        quote_d      = hcts_pkg::QT_NONE;
        phase_d      = hcts_pkg::PH_LEAD;
        pos_d        = '0;
        verdict_d    = hcts_pkg::VER_OPEN;
        res_o.valid  = matched;
        res_o.status = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inside_q  <= 1'b0;
      len_q     <= '0;
      quote_q   <= hcts_pkg::QT_NONE;
      phase_q   <= hcts_pkg::PH_LEAD;
      pos_q     <= '0;
      verdict_q <= hcts_pkg::VER_OPEN;
    end else if (step_i) begin
      inside_q  <= inside_d;
      len_q     <= len_d;
      quote_q   <= quote_d;
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      verdict_q <= verdict_d;
    end
  end

endmodule

/* design/hcts_out.sv */
// result register on the output channel
module hcts_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  hcts_pkg::res_t res_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           status_o
);

  logic valid_q, valid_d;
  logic status_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i && res_i.valid) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      status_q <= res_i.status;
    end
  end

  assign out_valid_o = valid_q;
  assign status_o    = status_q;

endmodule

/* design/html_embedded_close_tag_scanner.sv */
// top level of the embedded script, style and head close tag scanner
// an input transfer is held in the input register, then its result in the output register
// throughput: one byte per cycle, set by the single pass from input register to result register
// stall on the input follows a held result at the output register
// reset clears the scan state and selects the script word; no clearing pass
module html_embedded_close_tag_scanner #(
  parameter int TAG_BUFFER_SIZE = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       status_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  logic             in_v_q, in_v_d;
  hcts_pkg::step_t  in_q;
  hcts_pkg::kind_e  kind_q;
  hcts_pkg::res_t   res;
  logic             out_ready;
  logic             step;
  logic             in_xfer;

  assign step        = in_v_q && out_ready;
  assign in_stall_o  = in_v_q && !out_ready;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    in_v_d = in_v_q;
    if (in_xfer) begin
      in_v_d = 1'b1;
    end else if (step) begin
      in_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      kind_q <= hcts_pkg::KIND_SCRIPT;
    end else begin
      in_v_q <= in_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        kind_q <= hcts_pkg::kind_e'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.data_byte     <= data_byte_i;
      in_q.end_of_stream <= end_of_stream_i;
    end
  end

  hcts_scan #(
    .TAG_BUFFER_SIZE(TAG_BUFFER_SIZE)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .kind_i (kind_q),
    .res_o  (res)
  );

  hcts_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o)
  );

endmodule
